### sv/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and constants for the first-fit segment allocator
// Segment table geometry, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned MaxSegments = 16;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned IdxW        = $clog2(MaxSegments);
  localparam int unsigned CntW        = $clog2(MaxSegments + 1);
  localparam int unsigned SizeW       = 21;
  localparam int unsigned OffW        = 20;
  localparam int unsigned AccW        = 26;
  localparam logic [SizeW-1:0] RegionMax = SizeW'(1048576);
  localparam logic [SizeW-1:0] RegionMin = SizeW'(HeaderBytes + 1);

  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFree  = 2'd1;
  localparam logic [1:0] OpMerge = 2'd2;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoFit   = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StNull    = 3'd3;
  localparam logic [2:0] StUnknown = 3'd4;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ALLOC = 7'b0000010,
    S_FREE  = 7'b0000100,
    S_MERGE = 7'b0001000,
    S_SHIFT = 7'b0010000,
    S_PULL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

endpackage

### sv/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// Sequenced first-fit allocator over a sixteen-entry segment table.
// ----------------------------------------------------------------------------
// An allocate visits one entry per cycle, then moves the entries above the
// split one per cycle; a merge absorbs one neighbour at a time and pulls the
// rest of the table down one entry per cycle, so sixteen free segments take
// longest. One item at a time: in_stall_o is high until the result beat
// has been taken. Reset and a region_bytes write restore one free segment
// at once.
module first_fit_segment_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [0:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [ffsa_pkg::SizeW-1:0]   request_bytes_i,
  input  logic [ffsa_pkg::OffW-1:0]    free_offset_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ffsa_pkg::OffW-1:0]    payload_offset_o,
  output logic [2:0]                   status_o
);
  import ffsa_pkg::*;

  state_e                       state_q, state_d;
  logic [SizeW-1:0]             size_q [MaxSegments];
  logic [MaxSegments-1:0]       free_q;
  logic [CntW-1:0]              count_q;
  logic [SizeW-1:0]             region_q;
  logic [IdxW-1:0]              idx_q, pos_q;
  logic [AccW-1:0]              hdr_q;
  logic [SizeW-1:0]             req_q;
  logic [OffW-1:0]              off_q;
  logic [OffW-1:0]              pay_q;
  logic [2:0]                   st_q;
  logic                         outv_q;

  logic                         cfg_wr, in_acc;
  logic [SizeW-1:0]             wv, cur_sz, nxt_sz;
  logic [AccW-1:0]              need, hdr_plus;
  logic                         last;
  logic [CntW-1:0]              idx_ext;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata     = (paddr == 1'b0) ? 32'(region_q) : 32'd0;
  assign in_stall_o = (state_q != S_IDLE) || outv_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o      = outv_q;
  assign payload_offset_o = pay_q;
  assign status_o         = st_q;

  assign wv = (pwdata[SizeW-1:0] > RegionMax) ? RegionMax :
              (pwdata[SizeW-1:0] < RegionMin) ? RegionMin : pwdata[SizeW-1:0];

  // The shared unit: one entry size, the running header offset and a compare.
  assign cur_sz   = size_q[idx_q];
  assign nxt_sz   = size_q[idx_q + 1'b1];
  assign idx_ext  = CntW'(idx_q);
  assign last     = (idx_ext + 1'b1) >= count_q;
  assign need     = AccW'(req_q) + AccW'(HeaderBytes);
  assign hdr_plus = hdr_q + AccW'(HeaderBytes) + AccW'(cur_sz);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) begin
        unique case (op_i)
          OpAlloc: state_d = S_ALLOC;
          OpFree:  state_d = (free_offset_i == '0) ? S_DONE : S_FREE;
          OpMerge: state_d = (count_q > CntW'(1)) ? S_MERGE : S_DONE;
          default: state_d = S_DONE;
        endcase
      end
      S_ALLOC: begin
        if (free_q[idx_q] && (AccW'(cur_sz) > need))
          state_d = (count_q >= CntW'(MaxSegments)) ? S_DONE : S_SHIFT;
        else if (last) state_d = S_DONE;
      end
      S_FREE:  if ((hdr_q + AccW'(HeaderBytes) == AccW'(off_q)) || last) state_d = S_DONE;
      S_MERGE: begin
        if (free_q[idx_q] && free_q[idx_q + 1'b1]) state_d = S_PULL;
        else if ((idx_ext + 2'd2) >= count_q) state_d = S_DONE;
      end
      S_SHIFT: if (pos_q == idx_q) state_d = S_DONE;
      S_PULL:  if ((CntW'(pos_q) + 1'b1) >= count_q) begin
        state_d = ((idx_ext + 2'd2) >= count_q) ? S_DONE : S_MERGE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      outv_q   <= 1'b0;
      count_q  <= CntW'(1);
      free_q   <= MaxSegments'(1);
      region_q <= RegionMax;
      for (int k = 0; k < MaxSegments; k++)
        size_q[k] <= (k == 0) ? SizeW'(RegionMax - SizeW'(HeaderBytes)) : '0;
    end else begin
      state_q <= state_d;
      if (outv_q && !out_stall_i) outv_q <= 1'b0;
      if (cfg_wr) begin
        region_q <= wv;
        count_q  <= CntW'(1);
        free_q   <= MaxSegments'(1);
        for (int k = 0; k < MaxSegments; k++)
          size_q[k] <= (k == 0) ? SizeW'(wv - SizeW'(HeaderBytes)) : '0;
      end
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          req_q <= request_bytes_i;
          off_q <= free_offset_i;
          idx_q <= '0;
          hdr_q <= '0;
          pay_q <= '0;
          st_q  <= (op_i == OpFree && free_offset_i == '0) ? StNull : StOk;
        end
        S_ALLOC: begin
          if (free_q[idx_q] && (AccW'(cur_sz) > need)) begin
            if (count_q >= CntW'(MaxSegments)) st_q <= StFull;
            else begin
              pay_q <= OffW'(hdr_q + AccW'(HeaderBytes));
              pos_q <= IdxW'(count_q);
            end
          end else begin
            hdr_q <= hdr_plus;
            idx_q <= idx_q + 1'b1;
            if (last) st_q <= StNoFit;
          end
        end
        S_FREE: begin
          if (hdr_q + AccW'(HeaderBytes) == AccW'(off_q)) free_q[idx_q] <= 1'b1;
          else begin
            hdr_q <= hdr_plus;
            idx_q <= idx_q + 1'b1;
            if (last) st_q <= StUnknown;
          end
        end
        S_SHIFT: begin
          // Entries above the split move up one place, one per cycle.
          if (pos_q == idx_q) begin
            size_q[idx_q + 1'b1] <= SizeW'(AccW'(cur_sz) - need);
            free_q[idx_q + 1'b1] <= 1'b1;
            size_q[idx_q]        <= req_q;
            free_q[idx_q]        <= 1'b0;
            count_q              <= count_q + 1'b1;
          end else begin
            size_q[pos_q] <= size_q[pos_q - 1'b1];
            free_q[pos_q] <= free_q[pos_q - 1'b1];
            pos_q         <= pos_q - 1'b1;
          end
        end
        S_MERGE: begin
          if (free_q[idx_q] && free_q[idx_q + 1'b1]) begin
            size_q[idx_q] <= SizeW'(AccW'(cur_sz) + AccW'(HeaderBytes) + AccW'(nxt_sz));
            pos_q         <= idx_q + 1'b1;
          end else idx_q <= idx_q + 1'b1;
        end
        S_PULL: begin
          // Entries after the absorbed one move down one place per cycle.
          if ((CntW'(pos_q) + 1'b1) >= count_q) begin
            size_q[pos_q] <= '0;
            free_q[pos_q] <= 1'b0;
            count_q       <= count_q - 1'b1;
          end else begin
            size_q[pos_q] <= size_q[pos_q + 1'b1];
            free_q[pos_q] <= free_q[pos_q + 1'b1];
            pos_q         <= pos_q + 1'b1;
          end
        end
        S_DONE: outv_q <= 1'b1;
        default: ;
      endcase
    end
  end

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != S_IDLE) |-> in_stall_o;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(1)) && (count_q <= CntW'(MaxSegments)))
    else $error("segment count out of range");

  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> outv_q) else $error("result beat missing");

  a_fail_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outv_q && (st_q != StOk)) |-> (pay_q == '0)) else $error("payload on failure");

endmodule
